@@ hdl/sorted_sparse_term_accumulator_unit_assert.svh @@
// Assertion macros for the sorted sparse term accumulator.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef SORTED_SPARSE_TERM_ACCUMULATOR_UNIT_ASSERT_SVH
`define SORTED_SPARSE_TERM_ACCUMULATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSTA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ssta_pkg.sv @@
// Shared types, constants and helpers for the sorted sparse term accumulator.
// No dependencies; compiled first.
`default_nettype none

package ssta_pkg;

	localparam int MAX_TERMS = 64;
	localparam int CNT_W     = $clog2(MAX_TERMS + 1);
	localparam int PH_W      = $clog2(MAX_TERMS);
	localparam int EXP_W     = 16;
	localparam int COEFF_W   = 32;
	localparam int KEY_W     = 2 * EXP_W;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_SHIFT = 2'd1,
		CMD_DUMP  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic signed [EXP_W-1:0]   q;
		logic signed [EXP_W-1:0]   t;
		logic signed [COEFF_W-1:0] c;
	} term_t;

	// Operation broadcast to every cell of the row
	typedef enum logic [3:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INS,
		CELL_DEL,
		CELL_MRG,
		CELL_SHF,
		CELL_SRT_EVEN,
		CELL_SRT_ODD,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		term_t    arg;
		cnt_t     cnt;
	} cell_ctl_t;

	// Per-cell flags, OR-reduced across the row for the sequencer
	typedef struct packed {
		logic eq;
		logic sovf;
		logic szero;
		logic eovf;
	} cell_stat_t;

	// Sort key: t then q, sign bits flipped so unsigned compare gives signed order
	function automatic logic [KEY_W-1:0] key_of(input logic [EXP_W-1:0] q,
			input logic [EXP_W-1:0] t);
		return {~t[EXP_W-1], t[EXP_W-2:0], ~q[EXP_W-1], q[EXP_W-2:0]};
	endfunction

endpackage

`default_nettype wire

@@ hdl/ssta_chan_if.sv @@
// Valid/ready channel interfaces for command items and result items.
// Depends on ssta_pkg for field widths.
`default_nettype none

interface ssta_in_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         command;
	logic signed [ssta_pkg::EXP_W-1:0]   q_exp;
	logic signed [ssta_pkg::EXP_W-1:0]   t_exp;
	logic signed [ssta_pkg::COEFF_W-1:0] coeff;

	modport source (output valid, command, q_exp, t_exp, coeff, input ready);
	modport sink (input valid, command, q_exp, t_exp, coeff, output ready);
endinterface

interface ssta_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [ssta_pkg::EXP_W-1:0]   term_q;
	logic signed [ssta_pkg::EXP_W-1:0]   term_t;
	logic signed [ssta_pkg::COEFF_W-1:0] term_coeff;
	logic                               last;
	logic [ssta_pkg::CNT_W-1:0]          term_count;
	logic                               dropped;
	logic                               overflow;
	logic                               empty_res;

	modport source (output valid, term_q, term_t, term_coeff, last, term_count, dropped,
		overflow, empty_res, input ready);
	modport sink (input valid, term_q, term_t, term_coeff, last, term_count, dropped,
		overflow, empty_res, output ready);
endinterface

`default_nettype wire

@@ hdl/ssta_cell.sv @@
// One cell of the term row: holds a single term and its compare flags.
// Depends on ssta_pkg; neighbours are wired up by the top level.
`default_nettype none

module ssta_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssta_pkg::cell_ctl_t  ctl,
	input  ssta_pkg::cnt_t       idx,
	input  ssta_pkg::term_t      prev_term,
	input  ssta_pkg::term_t      next_term,
	input  ssta_pkg::term_t      head_term,
	input  logic                 prev_ge,
	output ssta_pkg::term_t      term,
	output logic                 ge,
	output ssta_pkg::cell_stat_t stat
);
	import ssta_pkg::*;

	term_t              term_q;
	logic [COEFF_W-1:0] sum_q;
	logic               ge_q;
	logic               gee_q;
	cell_stat_t         stat_q;

	logic               valid;
	logic               left_ok;
	logic               right_ok;
	logic               is_left;
	logic               tail;
	logic               eq_now;
	logic               sum_ovf;
	logic               q_ovf;
	logic               t_ovf;
	cnt_t               idx_nx;
	logic [KEY_W-1:0]   own_key;
	logic [KEY_W-1:0]   arg_key;
	logic [KEY_W-1:0]   next_key;
	logic [KEY_W-1:0]   prev_key;
	logic [COEFF_W-1:0] sum;
	logic [EXP_W-1:0]   q_sh;
	logic [EXP_W-1:0]   t_sh;

	// Position within the held prefix
	assign idx_nx   = idx + cnt_t'(1);
	assign valid    = idx < ctl.cnt;
	assign tail     = idx_nx == ctl.cnt;
	assign left_ok  = idx_nx < ctl.cnt;
	assign right_ok = valid && (idx != '0);
	assign is_left  = idx[0] ^ (ctl.op == CELL_SRT_EVEN);

	// Keys
	assign own_key  = key_of(term_q.q, term_q.t);
	assign arg_key  = key_of(ctl.arg.q, ctl.arg.t);
	assign next_key = key_of(next_term.q, next_term.t);
	assign prev_key = key_of(prev_term.q, prev_term.t);
	assign eq_now   = valid && (own_key == arg_key);

	// Coefficient merge and exponent shift, both wrapping
	assign sum     = term_q.c + ctl.arg.c;
	assign sum_ovf = (term_q.c[COEFF_W-1] == ctl.arg.c[COEFF_W-1]) &&
		(sum[COEFF_W-1] != term_q.c[COEFF_W-1]);
	assign q_sh    = term_q.q + ctl.arg.q;
	assign t_sh    = term_q.t + ctl.arg.t;
	assign q_ovf   = (term_q.q[EXP_W-1] == ctl.arg.q[EXP_W-1]) &&
		(q_sh[EXP_W-1] != term_q.q[EXP_W-1]);
	assign t_ovf   = (term_q.t[EXP_W-1] == ctl.arg.t[EXP_W-1]) &&
		(t_sh[EXP_W-1] != term_q.t[EXP_W-1]);

	// Compare and overflow flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q   <= 1'b0;
			gee_q  <= 1'b0;
			stat_q <= '0;
		end else begin
			case (ctl.op)
				CELL_CMP: begin
					ge_q         <= !valid || (own_key > arg_key);
					gee_q        <= !valid || (own_key >= arg_key);
					stat_q.eq    <= eq_now;
					stat_q.sovf  <= eq_now && sum_ovf;
					stat_q.szero <= eq_now && (sum == '0);
				end
				CELL_SHF: stat_q.eovf <= valid && (q_ovf || t_ovf);
				default: ;
			endcase
		end
	end

	// Term storage: insert, delete, merge, shift, sort and rotate
	always_ff @(posedge clk) begin
		if (ctl.op == CELL_CMP)
			sum_q <= sum;
		case (ctl.op) inside
			CELL_INS: begin
				if (prev_ge)
					term_q <= prev_term;
				else if (ge_q)
					term_q <= ctl.arg;
			end
			CELL_DEL: begin
				if (gee_q)
					term_q <= next_term;
			end
			CELL_MRG: begin
				if (stat_q.eq)
					term_q.c <= sum_q;
			end
			CELL_SHF: begin
				term_q.q <= q_sh;
				term_q.t <= t_sh;
			end
			CELL_SRT_EVEN, CELL_SRT_ODD: begin
				if (is_left && left_ok && (own_key > next_key))
					term_q <= next_term;
				else if (!is_left && right_ok && (prev_key > own_key))
					term_q <= prev_term;
			end
			CELL_ROT: begin
				if (tail)
					term_q <= head_term;
				else
					term_q <= next_term;
			end
			default: ;
		endcase
	end

	assign term = term_q;
	assign ge   = ge_q;
	assign stat = stat_q;

endmodule

`default_nettype wire

@@ hdl/ssta_ctrl.sv @@
// Sequencer for the term row: takes command items, drives the cell operation
// and holds the result register. Depends on ssta_pkg and the channel interfaces.
`default_nettype none
`include "sorted_sparse_term_accumulator_unit_assert.svh"

module ssta_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	ssta_in_if.sink              req,
	ssta_out_if.source           rsp,
	input  ssta_pkg::term_t      head_term,
	input  ssta_pkg::cell_stat_t any_stat,
	output ssta_pkg::cell_ctl_t  ctl
);
	import ssta_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_UPD,
		S_SHF,
		S_SCHK,
		S_SORT,
		S_DUMP,
		S_RES
	} state_t;

	localparam cnt_t           MAX_CNT = cnt_t'(MAX_TERMS);
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(MAX_TERMS - 1);

	state_t          state_q;
	term_t           arg_q;
	cnt_t            cnt_q;
	cnt_t            dmp_q;
	logic [PH_W-1:0] ph_q;
	logic            drp_q;
	logic            ovf_q;
	logic            emp_q;

	logic            out_free;
	logic            load_res;
	cnt_t            dmp_nx;

	assign out_free  = !rsp.valid || rsp.ready;
	assign load_res  = ((state_q == S_DUMP) || (state_q == S_RES)) && out_free;
	assign dmp_nx    = dmp_q + cnt_t'(1);
	assign req.ready = state_q == S_IDLE;

	// Cell operation for this cycle
	always_comb begin
		ctl.arg = arg_q;
		ctl.cnt = cnt_q;
		ctl.op  = CELL_HOLD;
		unique case (state_q)
			S_CMP:  ctl.op = CELL_CMP;
			S_UPD: begin
				if (any_stat.eq)
					ctl.op = any_stat.szero ? CELL_DEL : CELL_MRG;
				else if (cnt_q != MAX_CNT)
					ctl.op = CELL_INS;
			end
			S_SHF:  ctl.op = CELL_SHF;
			S_SORT: ctl.op = ph_q[0] ? CELL_SRT_ODD : CELL_SRT_EVEN;
			S_DUMP: begin
				if (out_free)
					ctl.op = CELL_ROT;
			end
			default: ;
		endcase
	end

	// State, count, flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			arg_q          <= '0;
			cnt_q          <= '0;
			dmp_q          <= '0;
			ph_q           <= '0;
			drp_q          <= 1'b0;
			ovf_q          <= 1'b0;
			emp_q          <= 1'b0;
			rsp.valid      <= 1'b0;
			rsp.term_q     <= '0;
			rsp.term_t     <= '0;
			rsp.term_coeff <= '0;
			rsp.last       <= 1'b0;
			rsp.term_count <= '0;
			rsp.dropped    <= 1'b0;
			rsp.overflow   <= 1'b0;
			rsp.empty_res  <= 1'b0;
		end else begin
			// result register loads or drains
			if (load_res)
				rsp.valid <= 1'b1;
			else if (rsp.ready)
				rsp.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						arg_q.q <= req.q_exp;
						arg_q.t <= req.t_exp;
						arg_q.c <= req.coeff;
						drp_q   <= 1'b0;
						ovf_q   <= 1'b0;
						emp_q   <= 1'b0;
						dmp_q   <= '0;
						unique case (cmd_t'(req.command))
							CMD_ADD:   state_q <= (req.coeff != '0) ? S_CMP : S_RES;
							CMD_SHIFT: state_q <= S_SHF;
							CMD_DUMP: begin
								if (cnt_q == '0) begin
									emp_q   <= 1'b1;
									state_q <= S_RES;
								end else begin
									state_q <= S_DUMP;
								end
							end
							CMD_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_RES;
							end
							default: state_q <= S_RES;
						endcase
					end
				end
				S_CMP: state_q <= S_UPD;
				S_UPD: begin
					if (any_stat.eq) begin
						ovf_q <= any_stat.sovf;
						if (any_stat.szero)
							cnt_q <= cnt_q - cnt_t'(1);
					end else if (cnt_q == MAX_CNT) begin
						drp_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + cnt_t'(1);
					end
					state_q <= S_RES;
				end
				S_SHF: state_q <= S_SCHK;
				S_SCHK: begin
					if (any_stat.eovf) begin
						ovf_q   <= 1'b1;
						ph_q    <= '0;
						state_q <= S_SORT;
					end else begin
						state_q <= S_RES;
					end
				end
				S_SORT: begin
					if (ph_q == PH_LAST)
						state_q <= S_RES;
					else
						ph_q <= ph_q + PH_W'(1);
				end
				S_DUMP: begin
					if (out_free) begin
						rsp.term_q     <= head_term.q;
						rsp.term_t     <= head_term.t;
						rsp.term_coeff <= head_term.c;
						rsp.last       <= dmp_nx == cnt_q;
						rsp.term_count <= cnt_q;
						rsp.dropped    <= 1'b0;
						rsp.overflow   <= 1'b0;
						rsp.empty_res  <= 1'b0;
						dmp_q          <= dmp_nx;
						if (dmp_nx == cnt_q)
							state_q <= S_IDLE;
					end
				end
				S_RES: begin
					if (out_free) begin
						rsp.term_q     <= '0;
						rsp.term_t     <= '0;
						rsp.term_coeff <= '0;
						rsp.last       <= 1'b1;
						rsp.term_count <= cnt_q;
						rsp.dropped    <= drp_q;
						rsp.overflow   <= ovf_q;
						rsp.empty_res  <= emp_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	`SSTA_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= MAX_CNT, "term count beyond table size")
	`SSTA_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_q != S_IDLE,
		"sequencer idle right after taking an item")
	`SSTA_ASSERT_NEXT(a_dump_end, (state_q == S_DUMP) && out_free && (dmp_nx == cnt_q),
		(state_q == S_IDLE) && rsp.valid && rsp.last, "dump did not close with last")
	`SSTA_ASSERT_NEXT(a_insert_grow,
		(state_q == S_UPD) && !any_stat.eq && (cnt_q != MAX_CNT),
		cnt_q == $past(cnt_q) + cnt_t'(1), "insert did not grow the table")

endmodule

`default_nettype wire

@@ hdl/sorted_sparse_term_accumulator_unit.sv @@
// Sorted sparse term accumulator: sequencer plus a row of term cells.
// Depends on ssta_pkg, ssta_chan_if, ssta_cell and ssta_ctrl.
//
// Usage:
//   req carries command items (add term, shift exponents, dump, clear) on a
//   valid/ready handshake; rsp carries result items the same way. One item
//   is processed at a time; req.ready is high only while the sequencer idles.
//   Add goes from acceptance to the result register through a compare in
//   every cell, then an insert, delete or merge across the row in one step;
//   a zero-coefficient add and clear go straight to the result register.
//   Shift adds the offsets to the exponents in every cell; when an exponent
//   wraps, the row then runs MAX_TERMS odd/even compare-swap phases between
//   neighbour cells. Dump rotates the row one cell per result, so n terms
//   give n results, the last one flagged; an empty dump gives one result.
//   The result register is single-entry. While it is full and rsp.ready is low,
//   no new result loads, the row does not rotate, and the result stays put.
//   Reset empties the table and clears the result register; there is no
//   clearing pass, since stale cells are never read.
`default_nettype none

module sorted_sparse_term_accumulator_unit (
	input logic        clk,
	input logic        arst_n,
	ssta_in_if.sink    req,
	ssta_out_if.source rsp
);
	import ssta_pkg::*;

	cell_ctl_t              ctl;
	term_t                  terms [MAX_TERMS];
	logic [MAX_TERMS-1:0]   ges;
	cell_stat_t             stats [MAX_TERMS];
	cell_stat_t             any_stat;

	// Flags from all cells folded for the sequencer
	always_comb begin
		any_stat = '0;
		for (int i = 0; i < MAX_TERMS; i++)
			any_stat = any_stat | stats[i];
	end

	ssta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.head_term (terms[0]),
		.any_stat  (any_stat),
		.ctl       (ctl)
	);

	// Row of cells, each wired to its neighbours
	for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
		term_t prv;
		term_t nxt;
		logic  prv_ge;

		if (g == 0) begin : g_first
			assign prv    = terms[0];
			assign prv_ge = 1'b0;
		end else begin : g_inner
			assign prv    = terms[g-1];
			assign prv_ge = ges[g-1];
		end

		if (g == MAX_TERMS - 1) begin : g_end
			assign nxt = terms[g];
		end else begin : g_next
			assign nxt = terms[g+1];
		end

		ssta_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.idx       (cnt_t'(g)),
			.prev_term (prv),
			.next_term (nxt),
			.head_term (terms[0]),
			.prev_ge   (prv_ge),
			.term      (terms[g]),
			.ge        (ges[g]),
			.stat      (stats[g])
		);
	end

endmodule

`default_nettype wire

@@ dv/ssta_term_checker.sv @@
`timescale 1ns / 100ps
// Checker for the sorted sparse term accumulator: watches the command and result channels,
// keeps its own sorted term table and compares each result item with the predicted one.
// Depends on ssta_pkg and the channel interfaces in ssta_chan_if.

module ssta_term_checker (
	input  logic clk,
	input  logic arst_n,
	ssta_in_if   req,
	ssta_out_if  rsp,
	output int   fail_count,
	output int   outstanding,
	output int   results_seen,
	output int   drops_seen,
	output int   wraps_seen,
	output int   empties_seen,
	output int   peak_terms
);
	import ssta_pkg::*;

	// One result item as it appears on the result channel
	typedef struct packed {
		term_t term;
		logic  last;
		cnt_t  count;
		logic  dropped;
		logic  overflow;
		logic  empty_res;
	} term_report_t;

	localparam int SHOWN_FAILURES = 10;

	term_t        model_row [MAX_TERMS];
	int           held;
	term_report_t due_reports [$];

	// Ordering: t first, then q, both as signed values
	function automatic logic [31:0] sort_key(input term_t e);
		return {e.t ^ 16'h8000, e.q ^ 16'h8000};
	endfunction

	function automatic logic add_wraps(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] s);
		return (a[15] == b[15]) && (s[15] != a[15]);
	endfunction

	function automatic string describe(input term_report_t r);
		return $sformatf("q=%0d t=%0d c=%0d last=%0b count=%0d dropped=%0b ovf=%0b empty=%0b",
			r.term.q, r.term.t, r.term.c, r.last, r.count, r.dropped, r.overflow,
			r.empty_res);
	endfunction

	task automatic queue_report(input term_t e, input logic last, input logic drp,
			input logic ovf, input logic emp);
		term_report_t r;
		r.term      = e;
		r.last      = last;
		r.count     = cnt_t'(held);
		r.dropped   = drp;
		r.overflow  = ovf;
		r.empty_res = emp;
		due_reports.push_back(r);
	endtask

	// Apply one command item to the local table and queue the result items it causes
	task automatic predict_command(input cmd_t cmd, input term_t arg);
		term_t       moving;
		logic [31:0] k;
		logic [31:0] sum;
		logic [15:0] s16;
		logic        drp;
		logic        ovf;
		logic        found;
		int          pos;
		int          i;
		int          j;
		drp = 1'b0;
		ovf = 1'b0;
		case (cmd)
			CMD_ADD: begin
				if (arg.c != 0) begin
					k     = sort_key(arg);
					pos   = held;
					found = 1'b0;
					for (i = 0; i < held; i++) begin
						if (sort_key(model_row[i]) == k) begin
							found = 1'b1;
							pos   = i;
							break;
						end
						if (sort_key(model_row[i]) > k) begin
							pos = i;
							break;
						end
					end
					if (found) begin
						// merge into the like term; a zero sum removes it
						sum = model_row[pos].c + arg.c;
						ovf = (model_row[pos].c[31] == arg.c[31]) && (sum[31] != arg.c[31]);
						if (sum == 0) begin
							for (i = pos; i < held - 1; i++)
								model_row[i] = model_row[i + 1];
							held--;
						end else begin
							model_row[pos].c = sum;
						end
					end else if (held >= MAX_TERMS) begin
						drp = 1'b1;
					end else begin
						for (i = held; i > pos; i--)
							model_row[i] = model_row[i - 1];
						model_row[pos] = arg;
						held++;
					end
				end
			end
			CMD_SHIFT: begin
				if (arg.q != 0 || arg.t != 0) begin
					for (i = 0; i < held; i++) begin
						s16 = model_row[i].q + arg.q;
						ovf |= add_wraps(model_row[i].q, arg.q, s16);
						model_row[i].q = s16;
						s16 = model_row[i].t + arg.t;
						ovf |= add_wraps(model_row[i].t, arg.t, s16);
						model_row[i].t = s16;
					end
					// wrapped exponents can break the order: sort again
					for (i = 1; i < held; i++) begin
						moving = model_row[i];
						j      = i;
						while (j > 0 && sort_key(model_row[j - 1]) > sort_key(moving)) begin
							model_row[j] = model_row[j - 1];
							j--;
						end
						model_row[j] = moving;
					end
				end
			end
			CMD_DUMP: begin
				if (held == 0)
					queue_report('0, 1'b1, 1'b0, 1'b0, 1'b1);
				for (i = 0; i < held; i++)
					queue_report(model_row[i], i == held - 1, 1'b0, 1'b0, 1'b0);
			end
			CMD_CLEAR: begin
				held = 0;
			end
		endcase
		if (cmd != CMD_DUMP)
			queue_report('0, 1'b1, drp, ovf, 1'b0);
		if (held > peak_terms)
			peak_terms = held;
	endtask

	task automatic log_failure(input string what);
		fail_count++;
		if (fail_count <= SHOWN_FAILURES)
			$display("%0t: %s", $time, what);
	endtask

	// Compare one accepted result item with the oldest prediction
	task automatic check_result();
		term_report_t got;
		term_report_t want;
		got.term.q    = rsp.term_q;
		got.term.t    = rsp.term_t;
		got.term.c    = rsp.term_coeff;
		got.last      = rsp.last;
		got.count     = rsp.term_count;
		got.dropped   = rsp.dropped;
		got.overflow  = rsp.overflow;
		got.empty_res = rsp.empty_res;
		results_seen++;
		if (got.dropped === 1'b1)
			drops_seen++;
		if (got.overflow === 1'b1)
			wraps_seen++;
		if (got.empty_res === 1'b1)
			empties_seen++;
		if (due_reports.size() == 0) begin
			log_failure({"result item with none expected: ", describe(got)});
		end else begin
			want = due_reports.pop_front();
			if (got !== want)
				log_failure({"result mismatch\n  expected ", describe(want),
					"\n  actual   ", describe(got)});
		end
	endtask

	// Results are checked before the same edge's command is predicted
	always @(posedge clk or negedge arst_n) begin : watch_channels
		term_t arg;
		if (!arst_n) begin
			held         = 0;
			due_reports.delete();
			fail_count   = 0;
			outstanding  = 0;
			results_seen = 0;
			drops_seen   = 0;
			wraps_seen   = 0;
			empties_seen = 0;
			peak_terms   = 0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_result();
			if (req.valid && req.ready) begin
				arg.q = req.q_exp;
				arg.t = req.t_exp;
				arg.c = req.coeff;
				predict_command(cmd_t'(req.command), arg);
			end
			outstanding = due_reports.size();
		end
	end

endmodule

@@ dv/sorted_sparse_term_accumulator_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sorted sparse term accumulator: clock, reset, command stimulus,
// result-side back-pressure, watchdog and verdict. Depends on ssta_pkg, ssta_chan_if,
// the block itself and ssta_term_checker.

module sorted_sparse_term_accumulator_unit_tb;
	import ssta_pkg::*;

	localparam int LONG_HOLD    = 200;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 4 * (4 + MAX_TERMS);
	localparam int RANDOM_ITEMS = 75;

	logic clk;
	logic arst_n;
	logic idle_on;
	int   long_holds_asked;
	int   items_sent;
	int   cmd_seen [4];

	int fail_count;
	int outstanding;
	int results_seen;
	int drops_seen;
	int wraps_seen;
	int empties_seen;
	int peak_terms;

	ssta_in_if  req_ch ();
	ssta_out_if rsp_ch ();

	sorted_sparse_term_accumulator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ssta_term_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.drops_seen   (drops_seen),
		.wraps_seen   (wraps_seen),
		.empties_seen (empties_seen),
		.peak_terms   (peak_terms)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Result side: random back-pressure, plus long hold-offs on request
	initial begin : result_sink
		int unsigned hold_left;
		int          holds_done;
		hold_left      = 0;
		holds_done     = 0;
		rsp_ch.ready   = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done < long_holds_asked) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 3) == 0)
					hold_left = gap_len();
			end
		end
	end

	// Watchdog: ends the run if no item moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("sorted_sparse_term_accumulator_unit verification failed");
		$finish;
	end

	// Optional gap, then offer one command item and wait for it to be taken
	task automatic send_item(input cmd_t cmd, input logic [15:0] q, input logic [15:0] t,
			input logic [31:0] c);
		int unsigned n;
		n = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		repeat (n) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.q_exp   <= q;
		req_ch.t_exp   <= t;
		req_ch.coeff   <= c;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		cmd_seen[int'(cmd)]++;
	endtask

	// Stop offering until every predicted result item has come back
	task automatic settle_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (outstanding == 0);
	endtask

	function automatic logic [15:0] near_exp();
		return 16'(int'($urandom_range(0, 6)) - 3);
	endfunction

	// One random command item; narrow keys make merges and removals common
	task automatic random_item();
		int unsigned roll;
		logic        narrow;
		logic [15:0] q;
		logic [15:0] t;
		logic [31:0] c;
		roll   = $urandom_range(0, 99);
		narrow = $urandom_range(0, 9) < 6;
		q      = narrow ? near_exp() : 16'($urandom());
		t      = narrow ? near_exp() : 16'($urandom());
		case ($urandom_range(0, 7))
			0:       c = '0;
			1:       c = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2, 3:    c = $urandom();
			default: c = 32'(int'($urandom_range(0, 8)) - 4);
		endcase
		if (roll < 60) begin
			send_item(CMD_ADD, q, t, c);
		end else if (roll < 73) begin
			if ($urandom_range(0, 9) < 7)
				send_item(CMD_SHIFT, 16'(int'($urandom_range(0, 4)) - 2),
					16'(int'($urandom_range(0, 4)) - 2), c);
			else
				send_item(CMD_SHIFT, 16'($urandom()), 16'($urandom()), c);
		end else if (roll < 95) begin
			send_item(CMD_DUMP, q, t, c);
		end else begin
			send_item(CMD_CLEAR, q, t, c);
		end
	endtask

	initial begin : stimulus
		logic [15:0] fill_q [MAX_TERMS];
		logic [31:0] fill_c [MAX_TERMS];
		int          i;
		arst_n           = 1'b0;
		idle_on          = 1'b1;
		long_holds_asked = 0;
		items_sent       = 0;
		for (i = 0; i < 4; i++)
			cmd_seen[i] = 0;
		req_ch.valid     = 1'b0;
		req_ch.command   = CMD_ADD;
		req_ch.q_exp     = '0;
		req_ch.t_exp     = '0;
		req_ch.coeff     = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty dump, zero coefficient, extremes, merge to zero, wraps
		send_item(CMD_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(CMD_ADD, 16'h0000, 16'h0000, 32'sd5);
		send_item(CMD_ADD, 16'sd7, 16'sd7, 32'h0000_0000);
		send_item(CMD_ADD, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF);
		send_item(CMD_ADD, 16'h8000, 16'h7FFF, 32'h8000_0000);
		send_item(CMD_ADD, 16'h0000, 16'h0000, -32'sd5);
		send_item(CMD_ADD, 16'h7FFF, 16'h8000, 32'sd1);
		send_item(CMD_ADD, 16'h8000, 16'h7FFF, 32'h8000_0000);
		send_item(CMD_ADD, -16'sd1, -16'sd1, 32'sd3);
		send_item(CMD_ADD, 16'sd1, -16'sd1, -32'sd7);
		send_item(CMD_ADD, 16'h8000, 16'h8000, 32'hFFFF_FFFF);
		send_item(CMD_DUMP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(CMD_SHIFT, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(CMD_SHIFT, 16'sd1, -16'sd1, 32'h0000_0000);
		send_item(CMD_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(CMD_SHIFT, 16'h8000, 16'h7FFF, 32'h0000_0000);
		send_item(CMD_SHIFT, 16'h7FFF, 16'h8000, 32'h0000_0000);
		send_item(CMD_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(CMD_CLEAR, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(CMD_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);
		settle_results();

		// Fill the table in scrambled t order; first half with no idling
		idle_on = 1'b0;
		for (i = 0; i < MAX_TERMS; i++) begin
			if (i == MAX_TERMS / 2)
				idle_on = 1'b1;
			// result side holds off while items keep coming
			if (i == 40)
				long_holds_asked++;
			fill_q[i] = 16'($urandom());
			fill_c[i] = $urandom();
			if (fill_c[i] == 0)
				fill_c[i] = 32'sd1;
			send_item(CMD_ADD, fill_q[i], 16'((i * 37) % 64 - 32), fill_c[i]);
		end
		// full table: new keys dropped, like terms still merge
		send_item(CMD_ADD, 16'h0000, 16'sd100, 32'sd9);
		send_item(CMD_ADD, 16'h8000, 16'h7FFF, 32'sd1);
		send_item(CMD_ADD, fill_q[3], 16'((3 * 37) % 64 - 32), 32'sd1);
		send_item(CMD_ADD, fill_q[7], 16'((7 * 37) % 64 - 32), -fill_c[7]);
		send_item(CMD_ADD, 16'h0000, 16'sd100, 32'sd9);
		send_item(CMD_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(CMD_SHIFT, 16'h4000, 16'h7FF0, 32'h0000_0000);
		send_item(CMD_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(CMD_CLEAR, 16'h0000, 16'h0000, 32'h0000_0000);
		settle_results();

		// Random mix, idling switched on and off every twenty items
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 20 == 0)
				idle_on = (i / 20) % 2 == 0;
			random_item();
		end
		send_item(CMD_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);

		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d command items (%0d add, %0d shift, %0d dump, %0d clear), %0d results.",
			items_sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], results_seen);
		$display("Drops %0d, wrap flags %0d, empty dumps %0d, table peaked at %0d terms.",
			drops_seen, wraps_seen, empties_seen, peak_terms);
		if (fail_count == 0 && outstanding == 0) begin
			$display("sorted_sparse_term_accumulator_unit verification clean");
		end else begin
			$display("sorted_sparse_term_accumulator_unit verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ssta_pkg.sv
hdl/ssta_chan_if.sv
hdl/ssta_cell.sv
hdl/ssta_ctrl.sv
hdl/sorted_sparse_term_accumulator_unit.sv
dv/ssta_term_checker.sv
dv/sorted_sparse_term_accumulator_unit_tb.sv
